>>> src/sac_lru_pkg.sv
// Shared types and constants of the set-associative LRU cache simulator.
// Used by the line compare unit and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sac_lru_pkg;

	localparam int ADDR_W     = 32;
	localparam int TAG_W      = 32;
	localparam int STAMP_W    = 32;
	localparam int TOTAL_W    = 32;
	localparam int CMD_W      = 2;
	localparam int WAY_OUT_W  = 3;
	localparam int OUT_DATA_W = 104;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_INSTR  = 2'd3
	} cmd_t;

	// One cache line as stored in the line memory
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	// Verdict of the line compare unit for one way
	typedef struct packed {
		logic hit;
		logic empty;
		logic older;
	} cmp_res_t;

endpackage

`default_nettype wire

>>> src/sac_lru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sac_lru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

>>> src/sac_lru_cmp.sv
// Line compare unit: tag match, empty check and LRU timestamp compare for one way.
// Depends on sac_lru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sac_lru_cmp (
	input  wire sac_lru_pkg::line_t                  line,
	input  wire logic [sac_lru_pkg::TAG_W-1:0]       key_tag,
	input  wire logic                                have_lru,
	input  wire logic [sac_lru_pkg::STAMP_W-1:0]     lru_stamp,
	output sac_lru_pkg::cmp_res_t                    res
);

	import sac_lru_pkg::*;

	always_comb begin
		res.hit   = line.valid && (line.tag == key_tag);
		res.empty = !line.valid;
		// a valid non-matching line that beats the current victim; ties keep the lower way
		res.older = line.valid && (line.tag != key_tag) &&
			(!have_lru || (line.stamp < lru_stamp));
	end

endmodule

`default_nettype wire

>>> src/set_assoc_cache_lru_sim_core.sv
// Top level of the set-associative LRU cache hit/miss simulator.
// Depends on sac_lru_pkg, sac_lru_ram and sac_lru_cmp.
//
// Usage:
//   Requests arrive on the s_ channel: s_tuser carries the command (load,
//   store, modify, instruction fetch), s_tdata the 32-bit byte address.
//   Each load, store or modify yields one result on the m_ channel; an
//   instruction fetch is accepted and dropped with no result.
//   The cfg_ channel writes set_bits (index 0), block_bits (1) and
//   ways_in_use (2); write only while no request is in flight.
//   Operation: a request is taken in the idle state, then each way of the set
//   is read from the single line memory port and compared in the shared
//   compare unit, stopping at the first hit or the last way in use (one way
//   on a hit in way 0, ways_in_use ways on a miss). The result is then
//   loaded into the output register. s_tready is high only in the idle
//   state, so a new request is accepted only after the last result is loaded.
//   Reset: the line memory is cleared by a pass over its 2^MAX_SET_BITS*MAX_WAYS
//   lines (512 by default), during which s_tready stays low.
//   Stall: a finished result waits in the output register; the next request
//   is still accepted, and its result holds until the receiver drains.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_sim_core #(
	parameter int MAX_SET_BITS = 6,
	parameter int MAX_WAYS     = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// request: tdata = address[31:0]; tuser = command[1:0]
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [sac_lru_pkg::ADDR_W-1:0]          s_tdata,
	input  wire logic [sac_lru_pkg::CMD_W-1:0]           s_tuser,
	// result: tdata = was_hit[0], did_evict[1], filled_way[4:2], hit_total[36:5],
	//         miss_total[68:37], evict_total[100:69], zero[103:101]
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [sac_lru_pkg::OUT_DATA_W-1:0]           m_tdata,
	// configuration write
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [sac_lru_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sac_lru_pkg::CFG_DATA_W-1:0]      cfg_data
);

	import sac_lru_pkg::*;

	localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int CNT_W  = $clog2(MAX_WAYS + 1);
	localparam int DEPTH  = (2 ** MAX_SET_BITS) * MAX_WAYS;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = SET_W + CNT_W;
	localparam int LINE_W = $bits(line_t);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CMP   = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// configuration registers
	logic [2:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;

	// running state
	logic [STAMP_W-1:0] clock_q;
	logic [TOTAL_W-1:0] hit_q, miss_q, evict_q;
	logic [IDX_W-1:0]   clr_q;

	// per-request scan registers
	logic [IDX_W-1:0]   base_q;
	logic [TAG_W-1:0]   tag_q;
	logic [CNT_W-1:0]   nw_q;
	logic               modify_q;
	logic [CNT_W-1:0]   way_q;
	logic               have_empty_q;
	logic [CNT_W-1:0]   empty_way_q;
	logic               have_lru_q;
	logic [STAMP_W-1:0] lru_stamp_q;
	logic [CNT_W-1:0]   lru_way_q;

	// finished result
	logic               res_hit_q, res_evict_q;
	logic [CNT_W-1:0]   res_way_q;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// effective geometry
	logic [2:0]       sb_eff;
	logic [CNT_W-1:0] nw_eff;
	logic [5:0]       tag_shift;
	logic [ADDR_W-1:0] set_full;
	logic [SET_W-1:0]  set_idx;
	logic [IDX_W-1:0]  base_d;
	logic [TAG_W-1:0]  tag_d;

	always_comb begin
		sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
		if (ways_q == 4'd0) begin
			nw_eff = CNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			nw_eff = CNT_W'(MAX_WAYS);
		end else begin
			nw_eff = CNT_W'(ways_q);
		end
		tag_shift = {1'b0, block_bits_q} + {3'b000, sb_eff};
		set_full  = (s_tdata >> block_bits_q) & ((32'd1 << sb_eff) - 32'd1);
		set_idx   = SET_W'(set_full);
		// shifts of 32 or more leave a zero tag
		tag_d     = s_tdata >> tag_shift;
		base_d    = IDX_W'(PROD_W'(set_idx) * PROD_W'(nw_eff));
	end

	// handshakes
	logic accept, scan_start, load_out;

	assign s_tready   = (state_q == ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign accept     = s_tvalid && s_tready;
	assign scan_start = accept && (s_tuser != CMD_INSTR);
	assign load_out   = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);

	// line memory and the shared compare unit
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	line_t             ram_wline, rd_line;
	logic [LINE_W-1:0] ram_rdata;
	cmp_res_t          cmp_res;

	sac_lru_ram #(
		.WIDTH (LINE_W),
		.DEPTH (DEPTH)
	) u_lines (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (LINE_W'(ram_wline)),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_line   = line_t'(ram_rdata);
	assign ram_raddr = base_q + IDX_W'(way_q);

	sac_lru_cmp u_cmp (
		.line      (rd_line),
		.key_tag   (tag_q),
		.have_lru  (have_lru_q),
		.lru_stamp (lru_stamp_q),
		.res       (cmp_res)
	);

	// fold the current way into the running empty / victim choice
	logic               emp_n;
	logic [CNT_W-1:0]   emp_way_n;
	logic               have_lru_n;
	logic [STAMP_W-1:0] lru_stamp_n;
	logic [CNT_W-1:0]   lru_way_n;
	logic               last_way, scan_done, evict_n;
	logic [CNT_W-1:0]   fin_way;

	always_comb begin
		emp_n       = have_empty_q || cmp_res.empty;
		emp_way_n   = have_empty_q ? empty_way_q : way_q;
		have_lru_n  = have_lru_q || cmp_res.older;
		lru_stamp_n = cmp_res.older ? rd_line.stamp : lru_stamp_q;
		lru_way_n   = cmp_res.older ? way_q : lru_way_q;
		last_way    = (way_q == nw_q - CNT_W'(1));
		scan_done   = (state_q == ST_CMP) && (cmp_res.hit || last_way);
		evict_n     = !cmp_res.hit && !emp_n;
		if (cmp_res.hit) begin
			fin_way = way_q;
		end else if (emp_n) begin
			fin_way = emp_way_n;
		end else begin
			fin_way = lru_way_n;
		end
	end

	// write port: clearing pass, or the hit / fill line at the end of a scan
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wline = '0;
		end else begin
			ram_we          = scan_done;
			ram_waddr       = base_q + IDX_W'(fin_way);
			ram_wline.valid = 1'b1;
			ram_wline.tag   = tag_q;
			ram_wline.stamp = clock_q;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_W'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (scan_start) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = scan_done ? ST_RESP : ST_READ;
			end
			ST_RESP: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			set_bits_q   <= 3'd0;
			block_bits_q <= 5'd0;
			ways_q       <= 4'd1;
			clock_q      <= '0;
			hit_q        <= '0;
			miss_q       <= '0;
			evict_q      <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);

			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_SET_BITS:   set_bits_q   <= cfg_data[2:0];
					REG_BLOCK_BITS: block_bits_q <= cfg_data;
					REG_WAYS:       ways_q       <= cfg_data[3:0];
					default: ; // drop writes beyond the register list
				endcase
			end

			// advance totals and the access clock once per load, store or modify request
			if (scan_done) begin
				clock_q <= clock_q + STAMP_W'(1);
				if (cmp_res.hit) begin
					hit_q <= hit_q + (modify_q ? TOTAL_W'(2) : TOTAL_W'(1));
				end else begin
					// the store half of a modify always hits the fresh line
					miss_q <= miss_q + TOTAL_W'(1);
					if (modify_q) hit_q <= hit_q + TOTAL_W'(1);
					if (evict_n) evict_q <= evict_q + TOTAL_W'(1);
				end
			end

			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (scan_start) begin
			base_q       <= base_d;
			tag_q        <= tag_d;
			nw_q         <= nw_eff;
			modify_q     <= (s_tuser == CMD_MODIFY);
			way_q        <= '0;
			have_empty_q <= 1'b0;
			have_lru_q   <= 1'b0;
		end else if (state_q == ST_CMP && !scan_done) begin
			way_q        <= way_q + CNT_W'(1);
			have_empty_q <= emp_n;
			empty_way_q  <= emp_way_n;
			have_lru_q   <= have_lru_n;
			lru_stamp_q  <= lru_stamp_n;
			lru_way_q    <= lru_way_n;
		end

		if (scan_done) begin
			res_hit_q   <= cmp_res.hit;
			res_evict_q <= evict_n;
			res_way_q   <= fin_way;
		end

		if (load_out) begin
			out_data_q <= {3'b000, evict_q, miss_q, hit_q,
				WAY_OUT_W'(res_way_q), res_evict_q, res_hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> clock_q == $past(clock_q) + STAMP_W'(1))
		else $error("access clock did not advance once at the end of a scan");

	a_miss_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CMP) |=> $stable(miss_q))
		else $error("miss total changed outside the compare step");

	a_way_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_CMP) |-> way_q < nw_q)
		else $error("way counter ran past the associativity");

	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == ST_CMP))
		else $error("line memory written outside clearing or compare");

endmodule

`default_nettype wire
